/* design/assert_macros.svh */
// Assertion macros shared by the downsampler modules.
// Each macro expects signals named clk and rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Condition holds at every clock edge out of reset.
`define AST_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Consequent holds in the cycle where the antecedent holds.
`define AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

/* design/mbad_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the masked block average downsampler.
// No dependencies.
package mbad_pkg;

  localparam int SAMPLE_W     = 8;
  localparam int QUOT_W       = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int LINE_REG_W   = 13;
  localparam int LOOKS_REG_W  = 5;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [LINE_REG_W-1:0]  LINE_WIDTH_RST = 13'd1024;
  localparam logic [LOOKS_REG_W-1:0] LOOKS_RST      = 5'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOOKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH_LOOKS = 2'd2;

  // Back-end divider sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } bk_state_t;

endpackage

/* design/mbad_queue.sv */
`timescale 1ns / 1ps
// Small register queue carrying finished block totals from front to back.
// Depends on mbad_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mbad_queue
  import mbad_pkg::*;
#(
  parameter int WIDTH = 26
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  output logic [WIDTH-1:0]                     rd_data,
  output logic                                 is_empty,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     level
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH+1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (int'(p) == QUEUE_DEPTH - 1) ? '0 : PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= bump(wptr);
      end
      if (rd_en) begin
        rptr <= bump(rptr);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= CW'(count + 1'b1);
        2'b01:   count <= CW'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  assign rd_data  = slots[rptr];
  assign is_empty = (count == '0);
  assign level    = count;

  `AST_IMPLY(no_underflow, rd_en, count != '0, "queue read while empty")
  `AST_IMPLY(no_overflow, wr_en && !rd_en, int'(count) < QUEUE_DEPTH, "queue write while full")

endmodule

/* design/mbad_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers, raster counters, column accumulator
// memory and block folding. Depends on mbad_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mbad_front
  import mbad_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int MAX_LOOKS      = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic signed [SAMPLE_W-1:0]        sample,
  output logic                              q_wr,
  output logic [SAMPLE_W+2*$clog2(MAX_LOOKS)+$clog2(MAX_LOOKS*MAX_LOOKS+1):0] q_wdata,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_level
);

  localparam int AW      = $clog2(MAX_LINE_WIDTH);
  localparam int LW_W    = $clog2(MAX_LINE_WIDTH + 1);
  localparam int LK_BITS = $clog2(MAX_LOOKS);
  localparam int LK_W    = $clog2(MAX_LOOKS + 1);
  localparam int IDX_W   = (LK_BITS > 0) ? LK_BITS : 1;
  localparam int CSUM_W  = SAMPLE_W + LK_BITS;
  localparam int CCNT_W  = $clog2(MAX_LOOKS + 1);
  localparam int BSUM_W  = SAMPLE_W + 2 * LK_BITS;
  localparam int BCNT_W  = $clog2(MAX_LOOKS * MAX_LOOKS + 1);
  localparam int COL_W   = CSUM_W + CCNT_W;

  typedef struct packed {
    logic first_row;
    logic last_row;
    logic last_look;
    logic line_last;
    logic line_end;
  } s1_flags_t;

  // Configuration registers
  logic [LINE_REG_W-1:0]  line_width;
  logic [LOOKS_REG_W-1:0] range_looks;
  logic [LOOKS_REG_W-1:0] azimuth_looks;
  logic                   cfg_hit;

  // Effective (clamped) settings
  logic [LW_W-1:0] lw_c;
  logic [LK_W-1:0] rl_c;
  logic [LK_W-1:0] al_c;

  // Raster counters
  logic [AW-1:0]    column_index;
  logic [IDX_W-1:0] row_in_group;
  logic [IDX_W-1:0] look_column;

  logic       in_acc;
  s1_flags_t  flags;

  // Stage 1
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic [AW-1:0]              s1_col;
  s1_flags_t                  s1_flags;

  logic [COL_W-1:0] col_mem [MAX_LINE_WIDTH];
  logic [COL_W-1:0] rd_q;
  logic             byp;
  logic [COL_W-1:0] byp_q;

  logic [COL_W-1:0]         base_word;
  logic signed [CSUM_W-1:0] base_sum;
  logic [CCNT_W-1:0]        base_cnt;
  logic signed [CSUM_W-1:0] csum;
  logic [CCNT_W-1:0]        ccnt;
  logic                     nz;
  logic [COL_W-1:0]         wr_word;

  logic signed [BSUM_W-1:0] block_sum;
  logic [BCNT_W-1:0]        block_count;
  logic signed [BSUM_W-1:0] fold_sum;
  logic [BCNT_W-1:0]        fold_cnt;
  logic                     fold_en;

  assign cfg_ready = 1'b1;

  always_comb begin
    case (cfg_index)
      REG_LINE_WIDTH:    cfg_hit = cfg_valid;
      REG_RANGE_LOOKS:   cfg_hit = cfg_valid;
      REG_AZIMUTH_LOOKS: cfg_hit = cfg_valid;
      default:           cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width    <= LINE_WIDTH_RST;
      range_looks   <= LOOKS_RST;
      azimuth_looks <= LOOKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINE_WIDTH:    line_width    <= cfg_data[LINE_REG_W-1:0];
        REG_RANGE_LOOKS:   range_looks   <= cfg_data[LOOKS_REG_W-1:0];
        REG_AZIMUTH_LOOKS: azimuth_looks <= cfg_data[LOOKS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one; anything past the limit acts as the limit.
  always_comb begin
    if (line_width == '0) begin
      lw_c = LW_W'(1);
    end else if (int'(line_width) > MAX_LINE_WIDTH) begin
      lw_c = LW_W'(MAX_LINE_WIDTH);
    end else begin
      lw_c = LW_W'(line_width);
    end
    if (range_looks == '0) begin
      rl_c = LK_W'(1);
    end else if (int'(range_looks) > MAX_LOOKS) begin
      rl_c = LK_W'(MAX_LOOKS);
    end else begin
      rl_c = LK_W'(range_looks);
    end
    if (azimuth_looks == '0) begin
      al_c = LK_W'(1);
    end else if (int'(azimuth_looks) > MAX_LOOKS) begin
      al_c = LK_W'(MAX_LOOKS);
    end else begin
      al_c = LK_W'(azimuth_looks);
    end
  end

  // Hold back input while the queue could not take this item and the one in stage 1.
  assign full   = (int'(q_level) + int'(s1_valid)) >= QUEUE_DEPTH;
  assign in_acc = push && !full;

  always_comb begin
    flags.first_row = (row_in_group == '0);
    flags.last_row  = (int'(row_in_group) + 1) >= int'(al_c);
    flags.last_look = (int'(look_column) + 1) >= int'(rl_c);
    flags.line_last = (int'(column_index) + 1) >= int'(lw_c);
    flags.line_end  = (int'(column_index) + 1 + int'(rl_c)) > int'(lw_c);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      column_index <= '0;
      row_in_group <= '0;
      look_column  <= '0;
    end else if (in_acc) begin
      if (flags.line_last) begin
        column_index <= '0;
        look_column  <= '0;
        row_in_group <= flags.last_row ? '0 : IDX_W'(row_in_group + 1'b1);
      end else begin
        column_index <= AW'(column_index + 1'b1);
        if (flags.last_row) begin
          look_column <= flags.last_look ? '0 : IDX_W'(look_column + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample <= sample;
      s1_col    <= column_index;
      s1_flags  <= flags;
      byp       <= s1_valid && (s1_col == column_index);
      byp_q     <= wr_word;
    end
  end

  // Column memory: read for the accepted sample, write back from stage 1.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      col_mem[s1_col] <= wr_word;
    end
    if (in_acc) begin
      rd_q <= col_mem[column_index];
    end
  end

  // Stage 1: update the column total; first row of a group starts fresh.
  always_comb begin
    base_word = byp ? byp_q : rd_q;
    base_sum  = s1_flags.first_row ? '0 : base_word[COL_W-1 -: CSUM_W];
    base_cnt  = s1_flags.first_row ? '0 : base_word[CCNT_W-1:0];
    nz        = (s1_sample != '0);
    csum      = base_sum + (nz ? CSUM_W'(s1_sample) : CSUM_W'(0));
    ccnt      = CCNT_W'(base_cnt + nz);
    wr_word   = {csum, ccnt};
    fold_en   = s1_flags.last_row && (csum != '0);
    fold_sum  = block_sum + (fold_en ? BSUM_W'(csum) : BSUM_W'(0));
    fold_cnt  = BCNT_W'(block_count + (fold_en ? BCNT_W'(ccnt) : BCNT_W'(0)));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      block_sum   <= '0;
      block_count <= '0;
    end else if (s1_valid) begin
      if (s1_flags.line_last || (s1_flags.last_row && s1_flags.last_look)) begin
        block_sum   <= '0;
        block_count <= '0;
      end else if (s1_flags.last_row) begin
        block_sum   <= fold_sum;
        block_count <= fold_cnt;
      end
    end
  end

  assign q_wr    = s1_valid && s1_flags.last_row && s1_flags.last_look;
  assign q_wdata = {fold_sum, fold_cnt, s1_flags.line_end};

  `AST_ALWAYS(col_in_line, int'(column_index) < int'(lw_c), "column index past line width")
  `AST_IMPLY(room_for_total, q_wr, int'(q_level) < QUEUE_DEPTH, "block total with queue full")

endmodule

/* design/mbad_back.sv */
`timescale 1ns / 1ps
// Back end: rounded division of block totals, one quotient bit per cycle,
// and the result register. Depends on mbad_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mbad_back
  import mbad_pkg::*;
#(
  parameter int BSUM_W = 16,
  parameter int BCNT_W = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [BSUM_W+BCNT_W:0]      q_rdata,
  output logic                        q_rd,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [SAMPLE_W-1:0]  average,
  output logic                        line_end
);

  localparam int RW = BSUM_W + BCNT_W + 1;
  localparam int SW = $clog2(QUOT_W);

  bk_state_t state;
  bk_state_t state_next;

  logic signed [BSUM_W-1:0] in_sum;
  logic [BCNT_W-1:0]        in_cnt;
  logic signed [RW-1:0]     sum_x;
  logic signed [RW-1:0]     mag_x;

  logic [RW-1:0]     rem;
  logic [RW-1:0]     dsh;
  logic [QUOT_W-1:0] quot;
  logic [SW-1:0]     step;
  logic              neg;
  logic              zero_cnt;
  logic              le_hold;

  logic out_valid;
  logic out_free;
  logic out_load;
  logic ge;

  assign in_sum   = q_rdata[BSUM_W+BCNT_W -: BSUM_W];
  assign in_cnt   = q_rdata[BCNT_W:1];
  assign sum_x    = RW'(in_sum);
  assign mag_x    = (in_sum < 0) ? -sum_x : sum_x;
  assign ge       = (rem >= dsh);
  assign out_free = !out_valid || pop;

  always_comb begin
    case (state)
      BK_IDLE: state_next = q_empty ? BK_IDLE : BK_DIV;
      BK_DIV:  state_next = (step == '0) ? BK_HOLD : BK_DIV;
      BK_HOLD: state_next = out_free ? BK_IDLE : BK_HOLD;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      BK_IDLE: begin
        q_rd     = !q_empty;
        out_load = 1'b0;
      end
      BK_HOLD: begin
        q_rd     = 1'b0;
        out_load = out_free;
      end
      default: begin
        q_rd     = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Quotient of (2|sum| + count) / (2 count); divisor starts at 2 count << 7.
  always_ff @(posedge clk) begin
    if (q_rd) begin
      rem      <= RW'(mag_x <<< 1) + RW'(in_cnt);
      dsh      <= RW'(in_cnt) << QUOT_W;
      quot     <= '0;
      step     <= SW'(QUOT_W - 1);
      neg      <= (in_sum < 0);
      zero_cnt <= (in_cnt == '0);
      le_hold  <= q_rdata[0];
    end else if (state == BK_DIV) begin
      if (ge) begin
        rem <= RW'(rem - dsh);
      end
      quot <= {quot[QUOT_W-2:0], ge};
      dsh  <= dsh >> 1;
      step <= SW'(step - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (zero_cnt) begin
        average <= '0;
      end else begin
        average <= neg ? SAMPLE_W'(-quot) : SAMPLE_W'(quot);
      end
      line_end <= le_hold;
    end
  end

  assign empty = !out_valid;

  `AST_IMPLY(load_from_hold, $rose(out_valid), $past(state) == BK_HOLD, "result without division")
  `AST_IMPLY(quot_in_range, state == BK_HOLD && !zero_cnt, int'(quot) <= 128, "quotient out of range")

endmodule

/* design/masked_block_average_downsampler_top.sv */
`timescale 1ns / 1ps
// Top level of the masked block average downsampler.
// Depends on mbad_pkg, mbad_front, mbad_queue and mbad_back.
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------
//   input     push / full          sample (s8)
//   result    empty / pop          average (s8), line_end
//   config    cfg_valid/cfg_ready  cfg_index (2b), cfg_data (13b)
//
// The front takes one sample per cycle whenever the queue has room; a column
// read-modify-write spans two stages with a forward for one-column lines.
// Each result passes through the back end as one load, eight divide steps in
// the shared compare-subtract unit and one hand-off; that unit sets the result
// rate, and full rises once the queued block totals plus the sample held in
// stage 1 reach four.
// Reset is synchronous; registers take 1024/4/4 and no clearing pass runs,
// since the first row of each group overwrites its column entries.
// A stalled result holds on the ports while the front runs on until the queue fills.
module masked_block_average_downsampler_top
  import mbad_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int MAX_LOOKS      = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic signed [SAMPLE_W-1:0]  sample,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [SAMPLE_W-1:0]  average,
  output logic                        line_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int LK_BITS = $clog2(MAX_LOOKS);
  localparam int BSUM_W  = SAMPLE_W + 2 * LK_BITS;
  localparam int BCNT_W  = $clog2(MAX_LOOKS * MAX_LOOKS + 1);
  localparam int ENTRY_W = BSUM_W + BCNT_W + 1;
  localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);

  // Block totals travel as {sum, count, line_end}.
  logic               q_wr;
  logic [ENTRY_W-1:0] q_wdata;
  logic               q_rd;
  logic [ENTRY_W-1:0] q_rdata;
  logic               q_empty;
  logic [QC_W-1:0]    q_level;

  // Front: count raster position, accumulate columns, fold blocks.
  mbad_front #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .MAX_LOOKS      (MAX_LOOKS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata),
    .q_level   (q_level)
  );

  // Decouple the two sides so either may stall.
  mbad_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr),
    .wr_data  (q_wdata),
    .rd_en    (q_rd),
    .rd_data  (q_rdata),
    .is_empty (q_empty),
    .level    (q_level)
  );

  // Back: divide and round, then present the beat until popped.
  mbad_back #(
    .BSUM_W (BSUM_W),
    .BCNT_W (BCNT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .average  (average),
    .line_end (line_end)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the masked block average downsampler: a scoreboard class predicts
// every block average and line mark, while plain tasks drive samples and register writes.
// Depends on mbad_pkg and masked_block_average_downsampler_top.
module testbench;
  import mbad_pkg::*;

  localparam int MAX_COLUMNS   = 4096;
  localparam int MAX_LOOKS_TB  = 16;
  localparam int RANDOM_ITEMS  = 200;
  // Allow generous slack for the divider path and the front end.
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 40;

  // Register index past the end of the list; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t average;
    logic    line_end;
  } block_result_t;

  // Tracks register contents and the per-column and per-block totals, and keeps the
  // averages still owed by the block in arrival order.
  class block_average_scoreboard;
    logic [LINE_REG_W-1:0]  line_width_reg;
    logic [LOOKS_REG_W-1:0] range_looks_reg;
    logic [LOOKS_REG_W-1:0] azimuth_looks_reg;
    int column_total[MAX_COLUMNS];
    int column_hits[MAX_COLUMNS];
    int group_row;
    int column;
    int block_column;
    int block_total;
    int block_hits;
    block_result_t expected_results[$];
    int produced;
    int mismatches;

    function new();
      line_width_reg    = LINE_WIDTH_RST;
      range_looks_reg   = LOOKS_RST;
      azimuth_looks_reg = LOOKS_RST;
      produced   = 0;
      mismatches = 0;
      restart_image();
    endfunction

    function void restart_image();
      group_row    = 0;
      column       = 0;
      block_column = 0;
      block_total  = 0;
      block_hits   = 0;
    endfunction

    // Zero acts as one; anything above the ceiling acts as the ceiling.
    function int effective(int value, int ceiling);
      if (value == 0) return 1;
      if (value > ceiling) return ceiling;
      return value;
    endfunction

    function int eff_line();
      return effective(int'(line_width_reg), MAX_COLUMNS);
    endfunction

    function int eff_range();
      return effective(int'(range_looks_reg), MAX_LOOKS_TB);
    endfunction

    function int eff_azimuth();
      return effective(int'(azimuth_looks_reg), MAX_LOOKS_TB);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_LINE_WIDTH:    line_width_reg    = data[LINE_REG_W-1:0];
        REG_RANGE_LOOKS:   range_looks_reg   = data[LOOKS_REG_W-1:0];
        REG_AZIMUTH_LOOKS: azimuth_looks_reg = data[LOOKS_REG_W-1:0];
        default:           return;
      endcase
      restart_image();
    endfunction

    // Half away from zero; hits is never zero here.
    function int rounded_mean(int total, int hits);
      int mag;
      int quot;
      mag  = (total < 0) ? -total : total;
      quot = (2 * mag + hits) / (2 * hits);
      return (total < 0) ? -quot : quot;
    endfunction

    function void note_sample(sample_t value);
      int lw;
      int rl;
      int az;
      int pixel;
      int col_sum;
      int col_hits;
      block_result_t res;
      lw    = eff_line();
      rl    = eff_range();
      az    = eff_azimuth();
      pixel = int'(value);
      // The first row of a group starts the column fresh.
      if (group_row == 0) begin
        col_sum  = 0;
        col_hits = 0;
      end else begin
        col_sum  = column_total[column];
        col_hits = column_hits[column];
      end
      if (pixel != 0) begin
        col_sum  += pixel;
        col_hits += 1;
      end
      column_total[column] = col_sum;
      column_hits[column]  = col_hits;
      if (group_row + 1 >= az) begin
        // A column that nets to zero drops out along with its count.
        if (col_sum != 0) begin
          block_total += col_sum;
          block_hits  += col_hits;
        end
        if (block_column + 1 >= rl) begin
          res.average  = (block_hits != 0) ? sample_t'(rounded_mean(block_total, block_hits))
                                           : '0;
          res.line_end = (column + 1 + rl > lw);
          expected_results.push_back(res);
          produced++;
          block_column = 0;
          block_total  = 0;
          block_hits   = 0;
        end else begin
          block_column++;
        end
      end
      if (column + 1 >= lw) begin
        column       = 0;
        block_column = 0;
        block_total  = 0;
        block_hits   = 0;
        group_row    = (group_row + 1 >= az) ? 0 : group_row + 1;
      end else begin
        column++;
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task check_result(sample_t got_average, logic got_line_end);
      block_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("average %0d line_end %0b with nothing outstanding",
                                  got_average, got_line_end));
        return;
      end
      want = expected_results.pop_front();
      if (got_average !== want.average)
        report_mismatch($sformatf("average %0d, predicted %0d", got_average, want.average));
      if (got_line_end !== want.line_end)
        report_mismatch($sformatf("line_end %0b, predicted %0b", got_line_end, want.line_end));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  push;
  logic                  full;
  sample_t               sample;
  logic                  empty;
  logic                  pop;
  sample_t               average;
  logic                  line_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  block_average_scoreboard board;
  sample_t directed_samples[$];
  bit no_idle = 1'b0;
  int hold_requests = 0;
  int cycle_count = 0;

  masked_block_average_downsampler_top DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .empty     (empty),
    .pop       (pop),
    .average   (average),
    .line_end  (line_end),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block wedges.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly no gap, some short ones, a rare long one; none at all in busy phases.
  function automatic int gap_len();
    int pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Favor masked pixels and corner values; now and then pick the value that cancels the
  // column total on the last row of a group, so whole columns net to zero.
  function automatic sample_t next_sample();
    int pick;
    int cancel;
    pick   = $urandom_range(0, 99);
    cancel = -board.column_total[board.column];
    if (pick < 12 && board.group_row != 0 && board.group_row + 1 >= board.eff_azimuth() &&
        cancel != 0 && cancel >= -128 && cancel <= 127)
      return sample_t'(cancel);
    if (pick < 35) return '0;
    if (pick < 50) begin
      case ($urandom_range(0, 5))
        0:       return 8'sd1;
        1:       return -8'sd1;
        2:       return 8'sd2;
        3:       return -8'sd2;
        4:       return 8'sd127;
        default: return -8'sd128;
      endcase
    end
    return sample_t'($urandom);
  endfunction

  // Random look count; the upper data bits are junk that the register must drop.
  function automatic logic [CFG_DATA_W-1:0] random_looks(int common_max);
    logic [LOOKS_REG_W-1:0] looks;
    case ($urandom_range(0, 19))
      0:       looks = '0;
      1:       looks = 5'($urandom_range(17, 31));
      2, 3, 4: looks = 5'($urandom_range(common_max + 1, 16));
      default: looks = 5'($urandom_range(1, common_max));
    endcase
    return {8'($urandom), looks};
  endfunction

  // Result side: pop at random, and honor a hold request by staying off for a long stretch.
  initial begin
    int gap_left;
    int holds_served;
    gap_left     = 0;
    holds_served = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        gap_left     = HOLD_CYCLES;
      end
      if (gap_left > 0) begin
        pop <= 1'b0;
        gap_left--;
      end else begin
        pop <= 1'b1;
        gap_left = gap_len();
      end
    end
  end

  // Check every result beat at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && pop && !empty) board.check_result(average, line_end);
  end

  // All driving tasks start and end just after a falling edge.

  // Offer one sample and hold it until accepted; leave push high for a following beat.
  task send_sample(input sample_t value);
    push   <= 1'b1;
    sample <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_sample(value);
    @(negedge clk);
  endtask

  task idle_input(input int cycles);
    if (cycles > 0) begin
      push <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task send_random(input int count);
    for (int k = 0; k < count; k++) begin
      idle_input(gap_len());
      send_sample(next_sample());
    end
  endtask

  task send_directed();
    foreach (directed_samples[k]) begin
      idle_input(gap_len());
      send_sample(directed_samples[k]);
    end
  endtask

  // Drop push, wait for every owed result, then let samples that make no result clear the
  // front end before anything else happens.
  task wait_idle();
    push <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no second assignment in one step.
  task write_register(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_register(index, data);
    @(negedge clk);
  endtask

  // Bit n of which selects a write to register n; bit 3 hits the unused index.
  task configure(input logic [3:0] which, input logic [CFG_DATA_W-1:0] lw_value,
                 input logic [CFG_DATA_W-1:0] rl_value, input logic [CFG_DATA_W-1:0] az_value,
                 input logic [CFG_DATA_W-1:0] spare_value);
    wait_idle();
    if (which[0]) write_register(REG_LINE_WIDTH, lw_value);
    if (which[1]) write_register(REG_RANGE_LOOKS, rl_value);
    if (which[2]) write_register(REG_AZIMUTH_LOOKS, az_value);
    if (which[3]) write_register(REG_UNUSED, spare_value);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int random_items;
    int items;
    int lw_e;
    int az_e;
    logic [3:0] which;
    logic [CFG_DATA_W-1:0] lw_value;
    logic [CFG_DATA_W-1:0] rl_value;
    logic [CFG_DATA_W-1:0] az_value;
    logic [CFG_DATA_W-1:0] spare_value;

    board = new();
    random_items = 0;
    push      = 1'b0;
    sample    = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst       = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Narrow the line only, so the reset look counts of four by four are exercised.
    configure(4'b0001, 13'd8, '0, '0, '0);
    send_random(64);

    // Corner values, an all-masked block, and rounding of a negative half.
    configure(4'b0111, 13'd4, 13'd2, 13'd1, '0);
    directed_samples = '{127, 127, -128, -128, 0, 0, 1, -2};
    send_directed();

    // A column netting to zero is skipped with its count; then start a group and leave it
    // open across a write to the unused index, which must not restart the image.
    configure(4'b0111, 13'd2, 13'd2, 13'd2, '0);
    directed_samples = '{5, 7, -5, 9, 1, 1};
    send_directed();
    configure(4'b1000, '0, '0, '0, 13'h1FFF);
    directed_samples = '{-1, 3};
    send_directed();

    // Zero in every register acts as one: each sample comes straight back.
    configure(4'b0111, '0, '0, '0, '0);
    directed_samples = '{-128, 0, 127, 1};
    send_directed();

    // Range looks wider than the line: nothing comes out.
    configure(4'b0111, 13'd3, 13'd5, 13'd1, '0);
    directed_samples = '{1, 2, 3};
    send_directed();

    // Trailing column past the last whole range group; halves round away from zero.
    configure(4'b0011, 13'd5, 13'd2, '0, '0);
    directed_samples = '{10, 21, -30, -41, 50};
    send_directed();

    // Largest block, look counts above the ceiling, most negative total.
    configure(4'b0111, 13'd16, 13'h1FFF, 13'd31, '0);
    for (int k = 0; k < 256; k++) begin
      idle_input(gap_len());
      send_sample(-8'sd128);
    end

    // One result per sample while the result side holds off: the queue fills and full
    // must stall the sender; the next configure then waits for every owed result.
    configure(4'b0111, 13'd4, 13'd1, 13'd1, '0);
    hold_requests++;
    no_idle = 1'b1;
    repeat (40) send_sample(next_sample());
    no_idle = 1'b0;

    // Random phases with mostly small geometry so results come often.
    while (random_items < RANDOM_ITEMS) begin
      which = 4'($urandom_range(1, 7));
      if ($urandom_range(0, 9) == 0) which[3] = 1'b1;
      case ($urandom_range(0, 19))
        0:       lw_value = '0;
        1, 2, 3: lw_value = 13'($urandom_range(25, 300));
        default: lw_value = 13'($urandom_range(1, 24));
      endcase
      rl_value    = random_looks(4);
      az_value    = random_looks(3);
      spare_value = 13'($urandom);
      lw_e = which[0] ? board.effective(int'(lw_value), MAX_COLUMNS) : board.eff_line();
      az_e = which[2] ? board.effective(int'(az_value[LOOKS_REG_W-1:0]), MAX_LOOKS_TB)
                      : board.eff_azimuth();
      // Keep a full row group short.
      if (lw_e * az_e > 400) begin
        which[2] = 1'b1;
        az_value = 13'($urandom_range(1, 2));
        az_e     = int'(az_value);
      end
      configure(which, lw_value, rl_value, az_value, spare_value);
      no_idle = ($urandom_range(0, 3) == 0);
      items = lw_e * az_e * $urandom_range(1, 3) + $urandom_range(0, lw_e);
      if (items > RANDOM_ITEMS - random_items) items = RANDOM_ITEMS - random_items;
      send_random(items);
      random_items += items;
    end
    no_idle = 1'b0;

    // Start a line at the widest setting, with the line width past the ceiling.
    configure(4'b0111, 13'h1FFF, 13'd16, 13'd1, '0);
    send_random(64);

    wait_idle();
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* masked_block_average_downsampler_top.f */
+incdir+design
design/mbad_pkg.sv
design/mbad_queue.sv
design/mbad_front.sv
design/mbad_back.sv
design/masked_block_average_downsampler_top.sv
bench/testbench.sv
